// ===== rtl/lcdws_pkg.sv =====
// lcdws_pkg: shared types, codes and the microcode program of the LCD write sequencer
// no dependencies; imported by char_lcd_parallel_write_sequencer_core
`default_nettype none

package lcdws_pkg;

  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_INIT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CMD    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DATA   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CURSOR = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCKS_PER_US = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_US      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_US      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXEC_US       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_UP_MS   = 3'd4;

  localparam logic [9:0] CLOCKS_PER_US_RST = 10'd168;
  localparam logic [7:0] SETUP_US_RST      = 8'd2;
  localparam logic [7:0] PULSE_US_RST      = 8'd2;
  localparam logic [9:0] EXEC_US_RST       = 10'd50;
  localparam logic [5:0] POWER_UP_MS_RST   = 6'd50;

  localparam int HOLD_W = 16;

  // hold source of a step
  localparam logic [1:0] HS_SETUP = 2'd0;
  localparam logic [1:0] HS_PULSE = 2'd1;
  localparam logic [1:0] HS_EXEC  = 2'd2;
  localparam logic [1:0] HS_POWER = 2'd3;

  // extra execute wait of a step
  localparam logic [2:0] EX_NONE = 3'd0;
  localparam logic [2:0] EX_1000 = 3'd1;
  localparam logic [2:0] EX_2000 = 3'd2;
  localparam logic [2:0] EX_5000 = 3'd3;
  localparam logic [2:0] EX_REQ  = 3'd4;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_INIT = 5'd0;
  localparam logic [PC_W-1:0] PC_BYTE = 5'd22;
  localparam logic [PC_W-1:0] PC_MAX  = 5'd24;

  typedef struct packed {
    logic       bus_const;
    logic [7:0] bus;
    logic       en;
    logic [1:0] hold_sel;
    logic [2:0] extra_sel;
    logic       fin;
  } ctl_t;

  function automatic ctl_t mk(input logic bc, input logic [7:0] b, input logic e,
                              input logic [1:0] hs, input logic [2:0] ex,
                              input logic f);
    ctl_t c;
    c.bus_const = bc;
    c.bus       = b;
    c.en        = e;
    c.hold_sel  = hs;
    c.extra_sel = ex;
    c.fin       = f;
    return c;
  endfunction

  // microcode: init program at 0..21, shared byte write at 22..24
  function automatic ctl_t prog_rom(input logic [PC_W-1:0] pc);
    ctl_t c;
    case (pc)
      5'd0:  c = mk(1'b1, 8'h00, 1'b0, HS_POWER, EX_NONE, 1'b0);
      5'd1:  c = mk(1'b1, 8'h38, 1'b0, HS_SETUP, EX_NONE, 1'b0);
      5'd2:  c = mk(1'b1, 8'h38, 1'b1, HS_PULSE, EX_NONE, 1'b0);
      5'd3:  c = mk(1'b1, 8'h38, 1'b0, HS_EXEC,  EX_5000, 1'b0);
      5'd4:  c = mk(1'b1, 8'h38, 1'b0, HS_SETUP, EX_NONE, 1'b0);
      5'd5:  c = mk(1'b1, 8'h38, 1'b1, HS_PULSE, EX_NONE, 1'b0);
      5'd6:  c = mk(1'b1, 8'h38, 1'b0, HS_EXEC,  EX_1000, 1'b0);
      5'd7:  c = mk(1'b1, 8'h38, 1'b0, HS_SETUP, EX_NONE, 1'b0);
      5'd8:  c = mk(1'b1, 8'h38, 1'b1, HS_PULSE, EX_NONE, 1'b0);
      5'd9:  c = mk(1'b1, 8'h38, 1'b0, HS_EXEC,  EX_1000, 1'b0);
      5'd10: c = mk(1'b1, 8'h08, 1'b0, HS_SETUP, EX_NONE, 1'b0);
      5'd11: c = mk(1'b1, 8'h08, 1'b1, HS_PULSE, EX_NONE, 1'b0);
      5'd12: c = mk(1'b1, 8'h08, 1'b0, HS_EXEC,  EX_1000, 1'b0);
      5'd13: c = mk(1'b1, 8'h01, 1'b0, HS_SETUP, EX_NONE, 1'b0);
      5'd14: c = mk(1'b1, 8'h01, 1'b1, HS_PULSE, EX_NONE, 1'b0);
      5'd15: c = mk(1'b1, 8'h01, 1'b0, HS_EXEC,  EX_2000, 1'b0);
      5'd16: c = mk(1'b1, 8'h06, 1'b0, HS_SETUP, EX_NONE, 1'b0);
      5'd17: c = mk(1'b1, 8'h06, 1'b1, HS_PULSE, EX_NONE, 1'b0);
      5'd18: c = mk(1'b1, 8'h06, 1'b0, HS_EXEC,  EX_1000, 1'b0);
      5'd19: c = mk(1'b1, 8'h0C, 1'b0, HS_SETUP, EX_NONE, 1'b0);
      5'd20: c = mk(1'b1, 8'h0C, 1'b1, HS_PULSE, EX_NONE, 1'b0);
      5'd21: c = mk(1'b1, 8'h0C, 1'b0, HS_EXEC,  EX_1000, 1'b1);
      5'd22: c = mk(1'b0, 8'h00, 1'b0, HS_SETUP, EX_NONE, 1'b0);
      5'd23: c = mk(1'b0, 8'h00, 1'b1, HS_PULSE, EX_NONE, 1'b0);
      5'd24: c = mk(1'b0, 8'h00, 1'b0, HS_EXEC,  EX_REQ,  1'b1);
      default: c = mk(1'b1, 8'h00, 1'b0, HS_SETUP, EX_NONE, 1'b1);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/char_lcd_parallel_write_sequencer_core.sv =====
// char_lcd_parallel_write_sequencer_core: 8-bit character LCD write sequencer,
// microcoded; each request is played out as timed pin segments. Uses lcdws_pkg.
//
//   channel | handshake              | payload
//   req     | req_valid / req_stall  | action, byte_value, line, column
//   seg     | seg_valid / seg_stall  | rs, rw, en, data_bus, hold_us, last
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one request at a time; each segment is presented and then held for
// hold_us microseconds by a microsecond prescaler and a hold counter,
// then the sequencer steps to the next segment, or back to idle after the last one
// seg_stall only delays the next segment load, hold timing starts at load
// rst (synchronous) resets control and config registers, not request/payload latches
`default_nettype none

module char_lcd_parallel_write_sequencer_core
  import lcdws_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire logic [ACT_W-1:0]      action,
  input  wire logic [7:0]            byte_value,
  input  wire logic [1:0]            line,
  input  wire logic [4:0]            column,

  output logic                       seg_valid,
  input  wire logic                  seg_stall,
  output logic                       rs,
  output logic                       rw,
  output logic                       en,
  output logic [7:0]                 data_bus,
  output logic [HOLD_W-1:0]          hold_us,
  output logic                       last,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]        state;
  logic [PC_W-1:0]   pc;
  logic [HOLD_W-1:0] hold_cnt;
  logic [9:0]        us_cnt;

  logic [9:0] clocks_per_us;
  logic [7:0] setup_us;
  logic [7:0] pulse_us;
  logic [9:0] exec_us;
  logic [5:0] power_up_ms;

  logic       req_rs;
  logic [7:0] req_byte;
  logic [2:0] req_extra;

  ctl_t              ctl;
  logic [HOLD_W-1:0] extra_val;
  logic [HOLD_W-1:0] power_val;
  logic [HOLD_W-1:0] hold_val;
  logic [7:0]        bus_val;
  logic              req_fire;
  logic              seg_fire;
  logic              seg_load;
  logic              go;
  logic              dec_rs;
  logic [7:0]        dec_byte;
  logic [2:0]        dec_extra;
  logic [PC_W-1:0]   dec_pc;
  logic [2:0]        ex_sel;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign seg_fire  = seg_valid && !seg_stall;
  assign seg_load  = (state == ST_EMIT) && (!seg_valid || !seg_stall);
  assign rw        = 1'b0;

  assign ctl = prog_rom(pc);

  // request decode
  always_comb begin
    go        = 1'b1;
    dec_rs    = 1'b0;
    dec_byte  = byte_value;
    dec_extra = EX_NONE;
    dec_pc    = PC_BYTE;
    case (action)
      ACT_INIT: begin
        dec_pc = PC_INIT;
      end
      ACT_CMD: begin
        dec_rs = 1'b0;
      end
      ACT_DATA: begin
        dec_rs = 1'b1;
      end
      ACT_CURSOR: begin
        go       = (line <= 2'd1) && (column <= 5'd15);
        dec_byte = {1'b1, line[0], 2'b00, column[3:0]};
      end
      ACT_CLEAR: begin
        dec_byte  = 8'h01;
        dec_extra = EX_2000;
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  // datapath for the current step
  assign ex_sel    = (ctl.extra_sel == EX_REQ) ? req_extra : ctl.extra_sel;
  // x * 1000 = x * 1024 - x * 16 - x * 8
  assign power_val = {power_up_ms, 10'b0} - {6'b0, power_up_ms, 4'b0}
                   - {7'b0, power_up_ms, 3'b0};
  assign bus_val   = ctl.bus_const ? ctl.bus : req_byte;

  always_comb begin
    case (ex_sel)
      EX_1000: extra_val = 16'd1000;
      EX_2000: extra_val = 16'd2000;
      EX_5000: extra_val = 16'd5000;
      default: extra_val = 16'd0;
    endcase
  end

  always_comb begin
    case (ctl.hold_sel)
      HS_SETUP: hold_val = {8'b0, setup_us};
      HS_PULSE: hold_val = {8'b0, pulse_us};
      HS_EXEC:  hold_val = {6'b0, exec_us} + extra_val;
      HS_POWER: hold_val = power_val;
      default:  hold_val = 16'd0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clocks_per_us <= CLOCKS_PER_US_RST;
      setup_us      <= SETUP_US_RST;
      pulse_us      <= PULSE_US_RST;
      exec_us       <= EXEC_US_RST;
      power_up_ms   <= POWER_UP_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLOCKS_PER_US: clocks_per_us <= cfg_data;
        REG_SETUP_US:      setup_us      <= cfg_data[7:0];
        REG_PULSE_US:      pulse_us      <= cfg_data[7:0];
        REG_EXEC_US:       exec_us       <= cfg_data;
        REG_POWER_UP_MS:   power_up_ms   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= PC_INIT;
      seg_valid <= 1'b0;
      hold_cnt  <= '0;
      us_cnt    <= '0;
    end else begin
      if (seg_load) begin
        seg_valid <= 1'b1;
      end else if (seg_fire) begin
        seg_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire && go) begin
            pc    <= dec_pc;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (seg_load) begin
            hold_cnt <= hold_val;
            us_cnt   <= clocks_per_us - 10'd1;
            state    <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (hold_cnt == '0) begin
            if (ctl.fin) begin
              state <= ST_IDLE;
            end else begin
              pc    <= pc + PC_W'(1);
              state <= ST_EMIT;
            end
          end else if (us_cnt == '0) begin
            us_cnt   <= clocks_per_us - 10'd1;
            hold_cnt <= hold_cnt - HOLD_W'(1);
          end else begin
            us_cnt <= us_cnt - 10'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request latch and segment payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_rs    <= dec_rs;
      req_byte  <= dec_byte;
      req_extra <= dec_extra;
    end
    if (seg_load) begin
      rs       <= ctl.bus_const ? 1'b0 : req_rs;
      en       <= ctl.en;
      data_bus <= bus_val;
      hold_us  <= hold_val;
      last     <= ctl.fin;
    end
  end

  a_seg_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(seg_valid) |-> $past(state == ST_EMIT))
    else $error("segment appeared outside an emit step");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (pc <= PC_MAX))
    else $error("step counter beyond program");

  a_en_not_last: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && en) |-> !last)
    else $error("enable-high segment flagged as last");

  a_hold_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && hold_cnt != '0) |=> (state == ST_WAIT))
    else $error("hold time cut short");

endmodule

`default_nettype wire
